// ----- rtl/core/cfr_pkg.sv -----
package cfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int WIN_DEPTH = 8;
    localparam int EPOCH_W   = 32;
    localparam int TICK_W    = 16;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/checksum_frame_resync.sv -----
// channel | signals                          | item
// rx      | rx_valid, rx_ready, rx_byte      | one received byte
// frame   | frame_valid, frame_ready,        | one matched frame
//         | command, sample_value,           |
//         | epoch_count, tick_count,         |
//         | frame_sum                        |
//
// One byte per cycle while rx_ready is high; the checksum over the newest
// seven of the eight cells is settled in the cycle the ninth byte arrives.
// A matched frame appears in the cycle after its last byte is accepted.
// Reset empties the window and drops any pending frame.
// rx_ready falls only while a frame waits in the output register and
// frame_ready is low.
module checksum_frame_resync (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rx_valid,
    output logic                          rx_ready,
    input  logic [cfr_pkg::BYTE_W-1:0]    rx_byte,
    output logic                          frame_valid,
    input  logic                          frame_ready,
    output logic [cfr_pkg::BYTE_W-1:0]    command,
    output logic [cfr_pkg::BYTE_W-1:0]    sample_value,
    output logic [cfr_pkg::EPOCH_W-1:0]   epoch_count,
    output logic [cfr_pkg::TICK_W-1:0]    tick_count,
    output logic [cfr_pkg::BYTE_W-1:0]    frame_sum
);
    import cfr_pkg::*;

    byte_t      byte_w  [0:WIN_DEPTH];
    byte_t      sum_w   [0:WIN_DEPTH];
    logic       valid_w [0:WIN_DEPTH];
    cell_ctrl_t ctrl;
    logic       accept;
    logic       full;
    logic       match;

    logic                 frame_valid_reg;
    logic                 frame_valid_next;
    byte_t                command_reg;
    byte_t                sample_reg;
    logic [EPOCH_W-1:0]   epoch_reg;
    logic [TICK_W-1:0]    tick_reg;
    byte_t                sum_reg;

    assign byte_w[WIN_DEPTH]  = rx_byte;
    assign valid_w[WIN_DEPTH] = 1'b1;
    assign sum_w[WIN_DEPTH]   = '0;

    // cell 0 holds the oldest byte, which is not part of the checksum
    for (genvar i = 0; i < WIN_DEPTH; i++)
    begin : g_cell
        cfr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .add_en    (i != 0),
            .byte_in   (byte_w[i+1]),
            .valid_in  (valid_w[i+1]),
            .sum_in    (sum_w[i+1]),
            .byte_out  (byte_w[i]),
            .valid_out (valid_w[i]),
            .sum_out   (sum_w[i])
        );
    end

    assign rx_ready   = !frame_valid_reg || frame_ready;
    assign accept     = rx_valid && rx_ready;
    assign full       = valid_w[0];
    assign match      = full && (sum_w[0] == rx_byte);
    assign ctrl.shift = accept;
    assign ctrl.clear = accept && match;

    always_comb
    begin
        frame_valid_next = frame_valid_reg && !frame_ready;
        if (accept && match)
        begin
            frame_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && match)
        begin
            command_reg <= byte_w[0];
            sample_reg  <= byte_w[1];
            epoch_reg   <= {byte_w[5], byte_w[4], byte_w[3], byte_w[2]};
            tick_reg    <= {byte_w[7], byte_w[6]};
            sum_reg     <= rx_byte;
        end
    end

    assign frame_valid  = frame_valid_reg;
    assign command      = command_reg;
    assign sample_value = sample_reg;
    assign epoch_count  = epoch_reg;
    assign tick_count   = tick_reg;
    assign frame_sum    = sum_reg;

    a_match_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && match |=> frame_valid)
        else $error("matched item did not produce a frame");

    a_match_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && match |=> !full)
        else $error("window not emptied after a match");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready |-> frame_valid && !frame_ready)
        else $error("input stalled without a pending frame");

    a_frame_sum: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> frame_sum == byte_t'(sample_value
            + epoch_count[7:0] + epoch_count[15:8]
            + epoch_count[23:16] + epoch_count[31:24]
            + tick_count[7:0] + tick_count[15:8]))
        else $error("frame checksum does not match its bytes");

endmodule

// ----- rtl/core/cfr_cell.sv -----
module cfr_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  cfr_pkg::cell_ctrl_t ctrl,
    input  logic               add_en,
    input  cfr_pkg::byte_t     byte_in,
    input  logic               valid_in,
    input  cfr_pkg::byte_t     sum_in,
    output cfr_pkg::byte_t     byte_out,
    output logic               valid_out,
    output cfr_pkg::byte_t     sum_out
);
    import cfr_pkg::*;

    byte_t byte_reg;
    byte_t byte_next;
    logic  valid_reg;
    logic  valid_next;

    always_comb
    begin
        byte_next  = ctrl.shift ? byte_in : byte_reg;
        valid_next = ctrl.shift ? valid_in : valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    // running checksum passes through the cell toward the oldest end
    assign sum_out   = add_en ? byte_t'(sum_in + byte_reg) : sum_in;
    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule
